// ===== rtl/core/rpd_pkg.sv =====
package rpd_pkg;

  localparam int KindW   = 2;
  localparam int HashW   = 16;
  localparam int PartW   = 8;
  localparam int TagW    = 2;
  localparam int SlotW   = 3;
  localparam int ServerW = 10;
  localparam int CountW  = 4;
  localparam int RandW   = 31;
  localparam int StatusW = 2;
  localparam int FoTagW  = 3;
  localparam int FoRegs  = 4;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 9;

  localparam logic [KindW-1:0] KIND_WR_BOUNDARY = 2'd0;
  localparam logic [KindW-1:0] KIND_WR_SLOT     = 2'd1;
  localparam logic [KindW-1:0] KIND_WR_COUNT    = 2'd2;
  localparam logic [KindW-1:0] KIND_LOOKUP      = 2'd3;

  localparam logic [StatusW-1:0] ST_WRITE_DONE = 2'd0;
  localparam logic [StatusW-1:0] ST_FOUND      = 2'd1;
  localparam logic [StatusW-1:0] ST_NO_SERVER  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_NUM_PARTITIONS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_TAG      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FAILOVER_A     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FAILOVER_B     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FAILOVER_C     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FAILOVER_D     = 3'd5;

  typedef struct packed {
    logic              start;
    logic [RandW-1:0]  dividend;
    logic [CountW-1:0] divisor;
  } rpd_mod_req_t;

  typedef struct packed {
    logic              done;
    logic [CountW-1:0] rem;
  } rpd_mod_rsp_t;

endpackage

// ===== rtl/core/rpd_ram.sv =====
module rpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rpd_mod.sv =====
module rpd_mod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rpd_pkg::rpd_mod_req_t req_i,
  output rpd_pkg::rpd_mod_rsp_t rsp_o
);
  import rpd_pkg::*;

  logic [31:0]       sh_q, sh_d;
  logic [CountW:0]   rem_q, rem_d;
  logic [CountW-1:0] div_q;
  logic [3:0]        cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;

  always_comb begin
    logic [CountW:0] r;
    r      = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      sh_d  = {1'b0, req_i.dividend};
      r     = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      for (int i = 0; i < 2; i++) begin
        r = {r[CountW-1:0], sh_q[31-i]};
        if (r >= {1'b0, div_q}) begin
          r = r - {1'b0, div_q};
        end
      end
      sh_d  = {sh_q[29:0], 2'b00};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      div_q <= req_i.divisor;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[CountW-1:0];

endmodule

// ===== rtl/core/range_partition_dispatch.sv =====
// Routes a key hash to a backend server. Each beat carries one item and yields one result:
// table writes (boundary, member slot, member count) are done in the execute state; a lookup
// runs a binary search over the boundary RAM across the effective partition count (one read
// and compare per step), one count RAM read and check per tag group tried (local tag, then
// failover tags), the two-bit-per-cycle modulo unit, and the member RAM read and result. After
// reset the member count RAM is cleared one entry per cycle, all PARTITIONS*TAGS entries, with
// input held off; configuration writes are taken at any time. Boundary and member slots must
// be written before a lookup reads them.
module range_partition_dispatch #(
  parameter int PARTITIONS    = 256,
  parameter int TAGS          = 4,
  parameter int SLOTS         = 8,
  parameter int FAILOVER_TAGS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rpd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rpd_pkg::KindW-1:0]     kind_i,
  input  logic [rpd_pkg::HashW-1:0]     hash_i,
  input  logic [rpd_pkg::PartW-1:0]     partition_i,
  input  logic [rpd_pkg::TagW-1:0]      tag_i,
  input  logic [rpd_pkg::SlotW-1:0]     slot_i,
  input  logic [rpd_pkg::ServerW-1:0]   server_i,
  input  logic [rpd_pkg::CountW-1:0]    count_i,
  input  logic [rpd_pkg::RandW-1:0]     rand_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rpd_pkg::StatusW-1:0]   status_o,
  output logic [rpd_pkg::ServerW-1:0]   pick_server_o,
  output logic [rpd_pkg::PartW-1:0]     partition_found_o
);
  import rpd_pkg::*;

  localparam int CDEPTH = PARTITIONS * TAGS;
  localparam int MDEPTH = PARTITIONS * TAGS * SLOTS;
  localparam int BAW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int MAW = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int SW  = $clog2(PARTITIONS + 1) + 1;
  localparam int PW  = $clog2(FAILOVER_TAGS + 2);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SCMP  = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd5;
  localparam logic [3:0] S_CCHK  = 4'd6;
  localparam logic [3:0] S_MOD   = 4'd7;
  localparam logic [3:0] S_MRD   = 4'd8;
  localparam logic [3:0] S_MDATA = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CAW:0] clr_q, clr_d;

  logic [8:0]        num_part_q;
  logic [TagW-1:0]   local_tag_q;
  logic [FoTagW-1:0] fo_q [FoRegs];

  logic [KindW-1:0]   kind_q;
  logic [HashW-1:0]   hash_q;
  logic [PartW-1:0]   part_q;
  logic [TagW-1:0]    tag_q;
  logic [SlotW-1:0]   slot_q;
  logic [ServerW-1:0] server_q;
  logic [CountW-1:0]  count_q;
  logic [RandW-1:0]   rand_q;

  logic signed [SW-1:0] left_q, left_d, right_q, right_d, mid_q, mid_d, mid_c;
  logic [PW-1:0]        pos_q, pos_d;
  logic [FoTagW-1:0]    use_tag_q, use_tag_d;
  logic [CountW-1:0]    n_q, n_d;
  logic [CountW-1:0]    pick_q, pick_d;

  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [ServerW-1:0] res_server_q, res_server_d;
  logic [PartW-1:0]   res_part_q, res_part_d;

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [ServerW-1:0] out_server_q;
  logic [PartW-1:0]   out_part_q;
  logic               out_load;

  logic               b_we, c_we, m_we;
  logic [BAW-1:0]     b_addr;
  logic [CAW-1:0]     c_addr;
  logic [MAW-1:0]     m_addr;
  logic [HashW-1:0]   b_rdata;
  logic [CountW-1:0]  c_wdata, c_rdata;
  logic [ServerW-1:0] m_rdata;

  rpd_mod_req_t mod_req;
  rpd_mod_rsp_t mod_rsp;

  logic              in_accept;
  logic              part_ok, tag_ok, slot_ok;
  int                eff;
  logic              pos_end, pos_valid, pos_in_range;
  logic [FoTagW-1:0] pos_tag;
  logic [31:0]       chosen_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign part_ok = (32'(part_q) < PARTITIONS);
  assign tag_ok  = (32'(tag_q) < TAGS);
  assign slot_ok = (32'(slot_q) < SLOTS);

  always_comb begin
    eff = int'(num_part_q);
    if (eff == 0) eff = 1;
    if (eff > PARTITIONS) eff = PARTITIONS;
  end

  assign mid_c      = left_q + ((right_q - left_q) >>> 1);
  assign chosen_ext = 32'(right_q);

  always_comb begin
    pos_end   = (32'(pos_q) > FAILOVER_TAGS);
    pos_valid = 1'b0;
    pos_tag   = '0;
    if (pos_q == '0) begin
      pos_valid = 1'b1;
      pos_tag   = {1'b0, local_tag_q};
    end else if (!pos_end && (32'(pos_q) <= FoRegs)) begin
      pos_tag   = fo_q[2'(pos_q - PW'(1))];
      pos_valid = !pos_tag[FoTagW-1];
    end
    pos_in_range = (32'(pos_tag) < TAGS);
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    left_d       = left_q;
    right_d      = right_q;
    mid_d        = mid_q;
    pos_d        = pos_q;
    use_tag_d    = use_tag_q;
    n_d          = n_q;
    pick_d       = pick_q;
    res_status_d = res_status_q;
    res_server_d = res_server_q;
    res_part_d   = res_part_q;
    out_load     = 1'b0;
    b_we         = 1'b0;
    c_we         = 1'b0;
    m_we         = 1'b0;
    b_addr       = BAW'(part_q);
    c_addr       = CAW'(32'(part_q) * TAGS + 32'(tag_q));
    c_wdata      = (32'(count_q) > SLOTS) ? CountW'(SLOTS) : count_q;
    m_addr       = MAW'((32'(part_q) * TAGS + 32'(tag_q)) * SLOTS + 32'(slot_q));
    mod_req.start    = 1'b0;
    mod_req.dividend = rand_q;
    mod_req.divisor  = n_q;
    unique case (state_q)
      S_CLR: begin
        c_we    = 1'b1;
        c_addr  = clr_q[CAW-1:0];
        c_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (32'(clr_q) == CDEPTH - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = ST_WRITE_DONE;
        res_server_d = '0;
        res_part_d   = '0;
        state_d      = S_FIN;
        unique case (kind_q)
          KIND_WR_BOUNDARY: b_we = part_ok;
          KIND_WR_SLOT:     m_we = part_ok && tag_ok && slot_ok;
          KIND_WR_COUNT:    c_we = part_ok && tag_ok;
          default: begin
            left_d  = '1;
            right_d = SW'(eff - 1);
            state_d = S_SRD;
          end
        endcase
      end
      S_SRD: begin
        if ((right_q - left_q) > SW'(1)) begin
          b_addr  = mid_c[BAW-1:0];
          mid_d   = mid_c;
          state_d = S_SCMP;
        end else begin
          pos_d   = '0;
          state_d = S_CRD;
        end
      end
      S_SCMP: begin
        if (b_rdata <= hash_q) begin
          left_d = mid_q;
        end else begin
          right_d = mid_q;
        end
        state_d = S_SRD;
      end
      S_CRD: begin
        res_part_d = chosen_ext[PartW-1:0];
        if (pos_end) begin
          res_status_d = ST_NO_SERVER;
          res_server_d = '0;
          state_d      = S_FIN;
        end else if (!pos_valid || !pos_in_range) begin
          pos_d = pos_q + 1'b1;
        end else begin
          c_addr    = CAW'(chosen_ext * TAGS + 32'(pos_tag));
          use_tag_d = pos_tag;
          state_d   = S_CCHK;
        end
      end
      S_CCHK: begin
        if (c_rdata != '0) begin
          n_d     = c_rdata;
          state_d = S_MOD;
          mod_req.start   = 1'b1;
          mod_req.divisor = c_rdata;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = S_CRD;
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          pick_d  = mod_rsp.rem;
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        m_addr  = MAW'((chosen_ext * TAGS + 32'(use_tag_q)) * SLOTS + 32'(pick_q));
        state_d = S_MDATA;
      end
      S_MDATA: begin
        res_status_d = ST_FOUND;
        res_server_d = m_rdata;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      num_part_q  <= 9'd1;
      local_tag_q <= '0;
      for (int i = 0; i < FoRegs; i++) fo_q[i] <= '1;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_NUM_PARTITIONS: num_part_q  <= cfg_data_i;
          CFG_LOCAL_TAG:      local_tag_q <= cfg_data_i[TagW-1:0];
          CFG_FAILOVER_A:     fo_q[0]     <= cfg_data_i[FoTagW-1:0];
          CFG_FAILOVER_B:     fo_q[1]     <= cfg_data_i[FoTagW-1:0];
          CFG_FAILOVER_C:     fo_q[2]     <= cfg_data_i[FoTagW-1:0];
          CFG_FAILOVER_D:     fo_q[3]     <= cfg_data_i[FoTagW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q   <= kind_i;
      hash_q   <= hash_i;
      part_q   <= partition_i;
      tag_q    <= tag_i;
      slot_q   <= slot_i;
      server_q <= server_i;
      count_q  <= count_i;
      rand_q   <= rand_value_i;
    end
    left_q       <= left_d;
    right_q      <= right_d;
    mid_q        <= mid_d;
    pos_q        <= pos_d;
    use_tag_q    <= use_tag_d;
    n_q          <= n_d;
    pick_q       <= pick_d;
    res_status_q <= res_status_d;
    res_server_q <= res_server_d;
    res_part_q   <= res_part_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_server_q <= res_server_q;
      out_part_q   <= res_part_q;
    end
  end

  rpd_ram #(.WIDTH(HashW), .DEPTH(PARTITIONS)) u_boundary_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .addr_i  (b_addr),
    .wdata_i (hash_q),
    .rdata_o (b_rdata)
  );

  rpd_ram #(.WIDTH(CountW), .DEPTH(CDEPTH)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .addr_i  (c_addr),
    .wdata_i (c_wdata),
    .rdata_o (c_rdata)
  );

  rpd_ram #(.WIDTH(ServerW), .DEPTH(MDEPTH)) u_member_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .addr_i  (m_addr),
    .wdata_i (server_q),
    .rdata_o (m_rdata)
  );

  rpd_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign pick_server_o     = out_server_q;
  assign partition_found_o = out_part_q;

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> in_stall_o)
    else $error("input accepted during count clear");

  a_server_only_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_FOUND)) |-> (pick_server_o == '0))
    else $error("server index set without a found status");

  a_write_no_partition: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_WRITE_DONE)) |-> (partition_found_o == '0))
    else $error("partition reported on a write");

  a_pick_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MRD) |-> (pick_q < n_q))
    else $error("member pick not below member count");

endmodule
